@@ src/continuous_batch_token_scheduler_unit_assert.svh @@
// assertion macros for the token scheduler
`ifndef CONTINUOUS_BATCH_TOKEN_SCHEDULER_UNIT_ASSERT_SVH
`define CONTINUOUS_BATCH_TOKEN_SCHEDULER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CBTS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define CBTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CBTS_ASSERT(label, clk, rst_n, prop)
`define CBTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/cbts_pkg.sv @@
package cbts_pkg;
    localparam int unsigned CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCHED = 2'd2;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_REQ_FULL = 2'd1;
    localparam logic [1:0] ST_PROMPT_FULL = 2'd2;
    localparam logic [0:0] REG_TOKEN_BUDGET = 1'd0;
    localparam logic [0:0] REG_ACTIVE_LIMIT = 1'd1;
    localparam logic [31:0] DECODE_BASE = 32'd9000;

    typedef struct packed {
        logic [1:0] command;
        logic [31:0] request_id;
        logic [9:0] gen_limit;
        logic [31:0] token_value;
    } cmd_t;

    typedef struct packed {
        logic [31:0] slot_request;
        logic [31:0] slot_token;
        logic [10:0] slot_position;
        logic prefill_slot;
        logic slot_valid;
        logic last;
        logic [1:0] status;
        logic sched_idle;
    } slot_t;

    typedef struct packed {
        logic index;
        logic [6:0] data;
    } cfg_t;
endpackage

@@ src/cbts_if.sv @@
interface cbts_cmd_if
    import cbts_pkg::*;
();
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cbts_slot_if
    import cbts_pkg::*;
();
    logic valid;
    logic ready;
    slot_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cbts_cfg_if
    import cbts_pkg::*;
();
    logic valid;
    logic ready;
    cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/cbts_ram.sv @@
module cbts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/continuous_batch_token_scheduler_unit.sv @@
// continuous batching token scheduler with chunked prefill
// cmd: one transaction per command (add request, append prompt token, schedule)
// slot: result transactions; add and append give one acknowledgement, a schedule
//   gives one transaction per prefill or decode slot, or one empty slot; last marks
//   the final transaction of a command
// cfg: index 0 token_budget, index 1 active_limit, written while idle (the block does not enforce this)
// add and append pass through S_ACK, which loads the acknowledgement into the output
//   register once it is free and returns to idle, where cmd is ready again
// a schedule runs a drop pass over the active entries, then admits waiting requests,
//   then runs the prefill and decode passes over the active entries; each slot goes
//   through a memory read state and an output state; 16 entries and at most
//   MAX_BUDGET (64) slots bound it
// each slot waits in a holding register until the next one is built, so the final
//   slot can carry last
// one command at a time: cmd ready only in the idle state
// per-entry prompt tokens live in a synchronous prompt memory; ids and limits in
//   per-entry memories; counts are small register files
// reset empties the waiting queue and active list, budget 8, limit 4
// when slot stalls, the sequencer holds its output register until taken
module continuous_batch_token_scheduler_unit
    import cbts_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned MAX_PROMPT = 64,
    parameter int unsigned MAX_GEN = 1024,
    parameter int unsigned MAX_BUDGET = 64
) (
    input logic clk,
    input logic rst_n,
    cbts_cmd_if.sink cmd,
    cbts_cfg_if.sink cfg,
    cbts_slot_if.source slot
);
`include "continuous_batch_token_scheduler_unit_assert.svh"
    localparam int unsigned EW = $clog2(MAX_ENTRIES);
    localparam int unsigned WD = 2 ** EW;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned PW = (MAX_PROMPT > 1) ? $clog2(MAX_PROMPT) : 1;
    localparam int unsigned LW = $clog2(MAX_PROMPT + 1);
    localparam int unsigned GW = $clog2(MAX_GEN + 1);
    localparam int unsigned AW = $clog2(MAX_ENTRIES * MAX_PROMPT);
    localparam int unsigned BW = 7;

    typedef enum logic [3:0] {
        S_IDLE, S_ACK, S_DROP, S_ADMIT, S_PF_SEL, S_PF_RD, S_PF_OUT,
        S_DC_SEL, S_DC_RD, S_DC_OUT, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic [6:0] budget_cfg_reg;
    logic [4:0] limit_cfg_reg;
    logic [LW-1:0] plen_reg [MAX_ENTRIES];
    logic [LW-1:0] pfc_reg [MAX_ENTRIES];
    logic [GW-1:0] gen_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] fin_reg;
    logic [MAX_ENTRIES-1:0] use_reg;
    logic [EW-1:0] wfifo_reg [WD];
    logic [EW-1:0] whead_reg;
    logic [CW-1:0] wcount_reg;
    logic [EW-1:0] order_reg [MAX_ENTRIES];
    logic [CW-1:0] acount_reg;
    logic [EW-1:0] newest_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] kept_reg;
    logic [BW-1:0] budget_reg;
    logic [LW-1:0] chunk_reg;
    logic [EW-1:0] ent_reg;
    logic any_reg;
    logic [1:0] st_reg;
    slot_t out_reg;
    slot_t hold_reg;
    slot_t hold_last;
    logic out_valid_reg;

    logic id_we, lim_we, pr_we;
    logic [EW-1:0] id_waddr;
    logic [31:0] id_rdata, pr_rdata;
    logic [9:0] lim_rdata;
    logic [AW-1:0] pr_waddr, pr_raddr;
    logic [EW-1:0] free_e;
    logic free_ok;
    logic [EW-1:0] cur_e;
    logic [CW-1:0] lim_eff;
    logic [BW-1:0] bud_eff;
    logic cmd_fire;
    logic done_now;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign slot.valid = out_valid_reg;
    assign slot.data = out_reg;
    assign cur_e = order_reg[idx_reg[EW-1:0]];
    assign done_now = (wcount_reg == '0) && (acount_reg == '0);

    always_comb
    begin
        hold_last = hold_reg;
        hold_last.last = 1'b1;
    end

    always_comb
    begin
        free_e = '0;
        free_ok = 1'b0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!use_reg[i])
            begin
                free_e = EW'(i);
                free_ok = 1'b1;
            end
        end
    end

    always_comb
    begin
        lim_eff = (32'(limit_cfg_reg) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
            : CW'(limit_cfg_reg);
        bud_eff = (budget_cfg_reg > 7'(MAX_BUDGET)) ? BW'(MAX_BUDGET) : budget_cfg_reg;
    end

    assign id_we = cmd_fire && cmd.data.command == CMD_ADD && free_ok
        && wcount_reg < CW'(MAX_ENTRIES);
    assign lim_we = id_we;
    assign id_waddr = free_e;
    assign pr_we = cmd_fire && cmd.data.command == CMD_APPEND && use_reg[newest_reg]
        && plen_reg[newest_reg] < LW'(MAX_PROMPT);
    assign pr_waddr = AW'(newest_reg) * AW'(MAX_PROMPT)
        + AW'(plen_reg[newest_reg][PW-1:0]);
    assign pr_raddr = AW'(ent_reg) * AW'(MAX_PROMPT)
        + AW'(pfc_reg[ent_reg][PW-1:0]);

    cbts_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_ids (
        .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(cmd.data.request_id),
        .raddr(ent_reg), .rdata(id_rdata)
    );
    cbts_ram #(.WIDTH(10), .DEPTH(MAX_ENTRIES)) u_lims (
        .clk(clk), .we(lim_we), .waddr(id_waddr), .wdata(cmd.data.gen_limit),
        .raddr(ent_reg), .rdata(lim_rdata)
    );
    cbts_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES * MAX_PROMPT)) u_prompt (
        .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(cmd.data.token_value),
        .raddr(pr_raddr), .rdata(pr_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            budget_cfg_reg <= 7'd8;
            limit_cfg_reg <= 5'd4;
            fin_reg <= '0;
            use_reg <= '0;
            whead_reg <= '0;
            wcount_reg <= '0;
            acount_reg <= '0;
            newest_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            hold_reg <= '0;
            idx_reg <= '0;
            kept_reg <= '0;
            budget_reg <= '0;
            chunk_reg <= '0;
            ent_reg <= '0;
            any_reg <= 1'b0;
            st_reg <= ST_OK;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                plen_reg[i] <= '0;
                pfc_reg[i] <= '0;
                gen_reg[i] <= '0;
                order_reg[i] <= '0;
            end
            for (int i = 0; i < WD; i++)
            begin
                wfifo_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.data.index == REG_TOKEN_BUDGET)
                begin
                    budget_cfg_reg <= cfg.data.data;
                end
                else
                begin
                    limit_cfg_reg <= cfg.data.data[4:0];
                end
            end
            if (out_valid_reg && slot.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        case (cmd.data.command)
                            CMD_ADD:
                            begin
                                state_reg <= S_ACK;
                                if (id_we)
                                begin
                                    st_reg <= ST_OK;
                                    use_reg[free_e] <= 1'b1;
                                    plen_reg[free_e] <= '0;
                                    pfc_reg[free_e] <= '0;
                                    gen_reg[free_e] <= '0;
                                    fin_reg[free_e] <= 1'b0;
                                    wfifo_reg[EW'(whead_reg + wcount_reg[EW-1:0])] <= free_e;
                                    wcount_reg <= wcount_reg + 1'b1;
                                    newest_reg <= free_e;
                                end
                                else
                                begin
                                    st_reg <= ST_REQ_FULL;
                                end
                            end
                            CMD_APPEND:
                            begin
                                state_reg <= S_ACK;
                                if (pr_we)
                                begin
                                    st_reg <= ST_OK;
                                    plen_reg[newest_reg] <= plen_reg[newest_reg] + 1'b1;
                                end
                                else if (use_reg[newest_reg])
                                begin
                                    st_reg <= ST_PROMPT_FULL;
                                end
                                else
                                begin
                                    st_reg <= ST_OK;
                                end
                            end
                            CMD_SCHED:
                            begin
                                state_reg <= S_DROP;
                                idx_reg <= '0;
                                kept_reg <= '0;
                                any_reg <= 1'b0;
                                budget_reg <= bud_eff;
                            end
                            default:
                            begin
                                st_reg <= ST_OK;
                                state_reg <= S_ACK;
                            end
                        endcase
                    end
                end
                S_ACK:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg <= '{slot_request: '0, slot_token: '0, slot_position: '0,
                            prefill_slot: 1'b0, slot_valid: 1'b0, last: 1'b1,
                            status: st_reg, sched_idle: done_now};
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_DROP:
                begin
                    if (idx_reg < acount_reg)
                    begin
                        if (fin_reg[cur_e])
                        begin
                            use_reg[cur_e] <= 1'b0;
                            fin_reg[cur_e] <= 1'b0;
                        end
                        else
                        begin
                            order_reg[kept_reg[EW-1:0]] <= cur_e;
                            kept_reg <= kept_reg + 1'b1;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        acount_reg <= kept_reg;
                        state_reg <= S_ADMIT;
                    end
                end
                S_ADMIT:
                begin
                    if (wcount_reg != '0 && acount_reg < lim_eff)
                    begin
                        order_reg[acount_reg[EW-1:0]] <= wfifo_reg[whead_reg];
                        acount_reg <= acount_reg + 1'b1;
                        whead_reg <= whead_reg + 1'b1;
                        wcount_reg <= wcount_reg - 1'b1;
                    end
                    else
                    begin
                        idx_reg <= '0;
                        state_reg <= S_PF_SEL;
                    end
                end
                S_PF_SEL:
                begin
                    if (idx_reg >= acount_reg)
                    begin
                        idx_reg <= '0;
                        state_reg <= S_DC_SEL;
                    end
                    else if (pfc_reg[cur_e] >= plen_reg[cur_e] || budget_reg == '0)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        ent_reg <= cur_e;
                        chunk_reg <= (32'(plen_reg[cur_e] - pfc_reg[cur_e]) > 32'(budget_reg))
                            ? LW'(budget_reg) : (plen_reg[cur_e] - pfc_reg[cur_e]);
                        state_reg <= S_PF_RD;
                    end
                end
                S_PF_RD:
                begin
                    state_reg <= S_PF_OUT;
                end
                S_PF_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        hold_reg <= '{slot_request: id_rdata, slot_token: pr_rdata,
                            slot_position: 11'(pfc_reg[ent_reg]), prefill_slot: 1'b1,
                            slot_valid: 1'b1, last: 1'b0, status: ST_OK,
                            sched_idle: done_now};
                        if (any_reg)
                        begin
                            out_reg <= hold_reg;
                            out_valid_reg <= 1'b1;
                        end
                        any_reg <= 1'b1;
                        pfc_reg[ent_reg] <= pfc_reg[ent_reg] + 1'b1;
                        budget_reg <= budget_reg - 1'b1;
                        chunk_reg <= chunk_reg - 1'b1;
                        if (chunk_reg == LW'(1))
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_PF_SEL;
                        end
                        else
                        begin
                            state_reg <= S_PF_RD;
                        end
                    end
                end
                S_DC_SEL:
                begin
                    if (idx_reg >= acount_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (pfc_reg[cur_e] < plen_reg[cur_e] || fin_reg[cur_e]
                        || budget_reg == '0)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        ent_reg <= cur_e;
                        state_reg <= S_DC_RD;
                    end
                end
                S_DC_RD:
                begin
                    state_reg <= S_DC_OUT;
                end
                S_DC_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        hold_reg <= '{slot_request: id_rdata,
                            slot_token: DECODE_BASE + 32'(gen_reg[ent_reg]),
                            slot_position: 11'(32'(plen_reg[ent_reg]) + 32'(gen_reg[ent_reg])
                                + 32'((gen_reg[ent_reg] < GW'(MAX_GEN)) ? 1 : 0) - 32'd1),
                            prefill_slot: 1'b0, slot_valid: 1'b1, last: 1'b0,
                            status: ST_OK, sched_idle: done_now};
                        if (any_reg)
                        begin
                            out_reg <= hold_reg;
                            out_valid_reg <= 1'b1;
                        end
                        any_reg <= 1'b1;
                        if (gen_reg[ent_reg] < GW'(MAX_GEN))
                        begin
                            gen_reg[ent_reg] <= gen_reg[ent_reg] + 1'b1;
                        end
                        if (32'(gen_reg[ent_reg]) + ((gen_reg[ent_reg] < GW'(MAX_GEN)) ? 32'd1 : 32'd0)
                            >= 32'(lim_rdata))
                        begin
                            fin_reg[ent_reg] <= 1'b1;
                        end
                        budget_reg <= budget_reg - 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_DC_SEL;
                    end
                end
                S_FIN:
                begin
                    if (!any_reg)
                    begin
                        st_reg <= ST_OK;
                        state_reg <= S_ACK;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg <= hold_last;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // last on the final slot: hold it back one step and mark it
    // the held slot is released from the S_OUT state through the same output register
    `CBTS_ASSERT(a_ready_idle, clk, rst_n, cmd.ready |-> state_reg == S_IDLE)
    `CBTS_ASSERT_NEXT(a_cmd_leaves_idle, clk, rst_n, cmd_fire, state_reg != S_IDLE)
    `CBTS_ASSERT_NEXT(a_slot_hold, clk, rst_n, slot.valid && !slot.ready, slot.valid && $stable(slot.data))
    `CBTS_ASSERT(a_active_bound, clk, rst_n, acount_reg <= CW'(MAX_ENTRIES))
    `CBTS_ASSERT(a_wait_bound, clk, rst_n, wcount_reg <= CW'(MAX_ENTRIES))
endmodule

@@ dv/cbts_tb_if.sv @@
`timescale 1ns / 100ps

interface cbts_mon_if
    import cbts_pkg::*;
();
    logic cmd_fire;
    cmd_t cmd_data;
    logic cfg_fire;
    cfg_t cfg_data;
    logic slot_fire;
    slot_t slot_data;
endinterface

@@ dv/cbts_scoreboard.sv @@
`timescale 1ns / 100ps

module cbts_scoreboard
    import cbts_pkg::*;
(
    input logic clk,
    input logic rst_n,
    cbts_mon_if mon,
    output int fail_count,
    output int pending,
    output int slots_seen,
    output int decodes_seen
);
    localparam int NE = 16;
    localparam int NP = 64;
    localparam int NG = 1024;
    localparam int NB = 64;

    logic [31:0] ids [NE];
    logic [31:0] prompts [NE*NP];
    int plen [NE];
    int pfill [NE];
    int gcnt [NE];
    int lim [NE];
    bit fin [NE];
    bit used [NE];
    int waitq [$];
    int act [$];
    int newest;
    int budget_reg;
    int limit_reg;
    slot_t expected_slots [$];

    task automatic report(input string what, input slot_t got, input slot_t want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    function automatic slot_t mk(input logic [31:0] r, input logic [31:0] t,
                                 input int p, input bit pre, input bit v,
                                 input logic [1:0] st);
        slot_t s;
        s = '0;
        s.slot_request = r;
        s.slot_token = t;
        s.slot_position = p[10:0];
        s.prefill_slot = pre;
        s.slot_valid = v;
        s.status = st;
        return s;
    endfunction

    task automatic predict_command(input cmd_t c);
        slot_t outs [$];
        logic [1:0] st;
        int e;
        int bud;
        int chunk;
        int k;
        int q [$];
        st = ST_OK;
        if (c.command == CMD_ADD)
        begin
            e = -1;
            for (int i = 0; i < NE; i++)
                if (!used[i] && e < 0) e = i;
            if (e < 0 || waitq.size() >= NE) st = ST_REQ_FULL;
            else
            begin
                used[e] = 1; ids[e] = c.request_id; lim[e] = c.gen_limit;
                plen[e] = 0; pfill[e] = 0; gcnt[e] = 0; fin[e] = 0;
                waitq = {waitq, e}; newest = e;
            end
        end
        else if (c.command == CMD_APPEND)
        begin
            if (used[newest])
            begin
                if (plen[newest] >= NP) st = ST_PROMPT_FULL;
                else
                begin
                    prompts[newest*NP + plen[newest]] = c.token_value;
                    plen[newest]++;
                end
            end
        end
        else if (c.command == CMD_SCHED)
        begin
            bud = budget_reg > NB ? NB : budget_reg;
            foreach (act[i])
            begin
                if (fin[act[i]])
                begin
                    used[act[i]] = 0; fin[act[i]] = 0;
                end
                else q = {q, act[i]};
            end
            act = q;
            while (waitq.size() > 0 && act.size() < limit_reg && act.size() < NE)
                act = {act, waitq.pop_front()};
            foreach (act[i])
            begin
                e = act[i];
                if (pfill[e] >= plen[e] || bud == 0) continue;
                chunk = plen[e] - pfill[e];
                if (chunk > bud) chunk = bud;
                for (int j = 0; j < chunk; j++)
                begin
                    k = pfill[e] + j;
                    outs = {outs, mk(ids[e], prompts[e*NP + (k % NP)], k, 1, 1, ST_OK)};
                end
                pfill[e] += chunk;
                bud -= chunk;
            end
            foreach (act[i])
            begin
                e = act[i];
                if (pfill[e] < plen[e] || fin[e] || bud == 0) continue;
                k = 9000 + gcnt[e];
                if (gcnt[e] < NG) gcnt[e]++;
                outs = {outs, mk(ids[e], k, plen[e] + gcnt[e] - 1, 0, 1, ST_OK)};
                decodes_seen++;
                bud--;
                if (gcnt[e] >= lim[e]) fin[e] = 1;
            end
        end
        if (outs.size() == 0) outs = {outs, mk(0, 0, 0, 0, 0, st)};
        outs[outs.size()-1].last = 1;
        foreach (outs[i])
        begin
            outs[i].sched_idle = (waitq.size() == 0 && act.size() == 0);
            expected_slots = {expected_slots, outs[i]};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slot_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NE; i++)
            begin
                plen[i] = 0; pfill[i] = 0; gcnt[i] = 0; fin[i] = 0; used[i] = 0;
            end
            waitq.delete(); act.delete(); expected_slots.delete();
            newest = 0; budget_reg = 8; limit_reg = 4;
            fail_count = 0; slots_seen = 0; decodes_seen = 0;
        end
        else
        begin
            if (mon.slot_fire)
            begin
                slots_seen++;
                if (expected_slots.size() == 0) report("unexpected", mon.slot_data, '0);
                else
                begin
                    want = expected_slots.pop_front();
                    if (mon.slot_data.slot_request !== want.slot_request)
                        report("slot_request", mon.slot_data, want);
                    if (mon.slot_data.slot_token !== want.slot_token)
                        report("slot_token", mon.slot_data, want);
                    if (mon.slot_data.slot_position !== want.slot_position)
                        report("slot_position", mon.slot_data, want);
                    if (mon.slot_data.prefill_slot !== want.prefill_slot)
                        report("prefill_slot", mon.slot_data, want);
                    if (mon.slot_data.slot_valid !== want.slot_valid)
                        report("slot_valid", mon.slot_data, want);
                    if (mon.slot_data.last !== want.last)
                        report("last", mon.slot_data, want);
                    if (mon.slot_data.status !== want.status)
                        report("status", mon.slot_data, want);
                    if (mon.slot_data.sched_idle !== want.sched_idle)
                        report("sched_idle", mon.slot_data, want);
                end
            end
            if (mon.cfg_fire)
            begin
                if (mon.cfg_data.index == REG_TOKEN_BUDGET) budget_reg = mon.cfg_data.data;
                else limit_reg = mon.cfg_data.data[4:0];
            end
            if (mon.cmd_fire) predict_command(mon.cmd_data);
        end
        pending = expected_slots.size();
    end

    final
    begin
        if (expected_slots.size() != 0)
            $display("%0d expected slot transactions never arrived", expected_slots.size());
    end
endmodule

@@ dv/tb_continuous_batch_token_scheduler_unit.sv @@
`timescale 1ns / 100ps

module tb_continuous_batch_token_scheduler_unit;
    import cbts_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    int fail_count;
    int pending;
    int slots_seen;
    int decodes_seen;
    int src_idle_pct = 38;
    int snk_idle_pct = 54;
    int quiet_cycles = 0;
    int items_sent = 0;
    bit timed_out = 0;

    cbts_cmd_if cmd_ch();
    cbts_cfg_if cfg_ch();
    cbts_slot_if slot_ch();
    cbts_mon_if mon();

    always #5 clk = ~clk;

    continuous_batch_token_scheduler_unit u_dut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_ch.sink), .cfg(cfg_ch.sink),
        .slot(slot_ch.source)
    );

    assign mon.cmd_fire = cmd_ch.valid && cmd_ch.ready;
    assign mon.cmd_data = cmd_ch.data;
    assign mon.cfg_fire = cfg_ch.valid && cfg_ch.ready;
    assign mon.cfg_data = cfg_ch.data;
    assign mon.slot_fire = slot_ch.valid && slot_ch.ready;
    assign mon.slot_data = slot_ch.data;

    cbts_scoreboard u_check (
        .clk(clk), .rst_n(rst_n), .mon(mon), .fail_count(fail_count),
        .pending(pending), .slots_seen(slots_seen), .decodes_seen(decodes_seen)
    );

    initial
    begin
        cmd_ch.valid = 0;
        cmd_ch.data = '0;
        cfg_ch.valid = 0;
        cfg_ch.data = '0;
        slot_ch.ready = 0;
    end

    always @(posedge clk)
    begin
        slot_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        if (mon.cmd_fire || mon.slot_fire || mon.cfg_fire) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000 && !timed_out)
        begin
            timed_out = 1;
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send(input logic [1:0] c, input logic [31:0] id,
                        input logic [9:0] gl, input logic [31:0] tok);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1;
        cmd_ch.data <= '{command: c, request_id: id, gen_limit: gl, token_value: tok};
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        cmd_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        drain();
        cfg_ch.valid <= 1;
        cfg_ch.data <= '{index: idx, data: val};
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 0;
        @(posedge clk);
    endtask

    task automatic add_with_prompt(input int plen, input logic [9:0] gl);
        send(CMD_ADD, $urandom(), gl, 0);
        for (int i = 0; i < plen; i++) send(CMD_APPEND, 0, 0, $urandom());
    endtask

    task automatic random_phase(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 20) add_with_prompt($urandom_range(4), 10'($urandom_range(6)));
            else if (r < 75) send(CMD_SCHED, 0, 0, 0);
            else if (r < 85) send(CMD_APPEND, 0, 0, $urandom());
            else if (r < 92) send(CMD_ADD, $urandom(), 10'($urandom_range(1023)), 0);
            else if (r < 96) send(2'd3, $urandom(), 10'($urandom()), $urandom());
            else add_with_prompt(1, 0);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: empty step, append with no request, unused command
        send(CMD_SCHED, 0, 0, 0);
        send(CMD_APPEND, 0, 0, 32'hffff_ffff);
        send(2'd3, 32'hffff_ffff, 10'h3ff, 32'hffff_ffff);
        send(CMD_ADD, 32'hffff_ffff, 10'h3ff, 0);
        send(CMD_APPEND, 0, 0, 32'hffff_ffff);
        send(CMD_APPEND, 0, 0, 0);
        send(CMD_ADD, 0, 0, 0);
        send(CMD_APPEND, 0, 0, 32'h5555_aaaa);
        send(CMD_SCHED, 0, 0, 0);
        send(CMD_APPEND, 0, 0, 32'haaaa_5555);
        send(CMD_SCHED, 0, 0, 0);
        send(CMD_SCHED, 0, 0, 0);
        // prompt store full
        write_reg(REG_TOKEN_BUDGET, 7'd64);
        add_with_prompt(64, 2);
        send(CMD_APPEND, 0, 0, 32'h1234);
        send(CMD_SCHED, 0, 0, 0);
        send(CMD_SCHED, 0, 0, 0);
        // request store full
        for (int i = 0; i < 17; i++) send(CMD_ADD, i, 1, 0);
        write_reg(REG_ACTIVE_LIMIT, 7'd16);
        write_reg(REG_TOKEN_BUDGET, 7'd127);
        for (int i = 0; i < 4; i++) send(CMD_SCHED, 0, 0, 0);
        random_phase(60);
        write_reg(REG_TOKEN_BUDGET, 7'd0);
        write_reg(REG_ACTIVE_LIMIT, 7'd0);
        random_phase(20);
        write_reg(REG_TOKEN_BUDGET, 7'd1);
        write_reg(REG_ACTIVE_LIMIT, 7'd31);
        src_idle_pct = 54;
        snk_idle_pct = 38;
        random_phase(60);
        drain();
        write_reg(REG_TOKEN_BUDGET, 7'd5);
        write_reg(REG_ACTIVE_LIMIT, 7'd1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(40);
        write_reg(REG_TOKEN_BUDGET, 7'd12);
        write_reg(REG_ACTIVE_LIMIT, 7'd4);
        random_phase(35);
        drain();
        $display("sent %0d commands, checked %0d slot transactions (%0d decode)",
                 items_sent, slots_seen, decodes_seen);
        if (fail_count == 0 && pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+src
src/cbts_pkg.sv
src/cbts_if.sv
src/cbts_ram.sv
src/continuous_batch_token_scheduler_unit.sv
dv/cbts_tb_if.sv
dv/cbts_scoreboard.sv
dv/tb_continuous_batch_token_scheduler_unit.sv
